FILE: sv/stable_priority_queue_macros.svh
// Assertion macros used by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// Types and codes shared by the stable priority queue modules.
`default_nettype none

package spq_pkg;

    // Input kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry
    typedef struct packed {
        logic [7:0] id;
        logic [2:0] prio;
    } t_entry;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_op;

    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_cell_cmd;

    // Registered result word
    typedef struct packed {
        t_status    status;
        logic [7:0] out_id;
        logic [2:0] out_prio;
        logic [4:0] occupancy;
    } t_rsp;

endpackage

`default_nettype wire

FILE: sv/spq_req_if.sv
// Request channel: valid/ready handshake carrying one queue command word.
`default_nettype none

interface spq_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] request_id;
    logic [2:0] prio;

    modport source (output valid, output kind, output request_id, output prio,
                    input ready);
    modport sink   (input valid, input kind, input request_id, input prio,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/spq_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`default_nettype none

interface spq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_id;
    logic [2:0] out_prio;
    logic [4:0] occupancy;

    modport source (output valid, output status, output out_id, output out_prio,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_prio,
                    input occupancy, output ready);
endinterface

`default_nettype wire

FILE: sv/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts left or right, or takes a new entry.
`default_nettype none

module spq_cell (
    input  wire logic              i_clk,
    input  wire spq_pkg::t_cell_cmd i_cmd,
    input  wire logic              i_occ,
    input  wire spq_pkg::t_entry   i_left,
    input  wire logic              i_left_behind,
    input  wire spq_pkg::t_entry   i_right,
    output spq_pkg::t_entry        o_entry,
    output logic                   o_behind
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // New entry must go behind this slot when it holds equal or higher priority
    assign o_behind = i_occ && (r_entry.prio >= i_cmd.entry.prio);
    assign o_entry  = r_entry;

    // Pick the next slot content
    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            spq_pkg::OP_INSERT: begin
                if (o_behind) begin
                    n_entry = r_entry;
                end else if (i_left_behind) begin
                    n_entry = i_cmd.entry;
                end else begin
                    n_entry = i_left;
                end
            end
            spq_pkg::OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

FILE: sv/stable_priority_queue.sv
// A result word is registered when its command word is accepted and is valid in the next cycle.
// Throughput: one insert or pop per cycle while results are taken; every cell of the chain updates in parallel.
// The output register frees the next command whenever the result is taken or absent.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// slot contents are left as they are and no clearing pass is needed.
`default_nettype none

`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_rsp_valid;
    logic                n_rsp_valid;
    spq_pkg::t_rsp       r_rsp;
    spq_pkg::t_rsp       n_rsp;
    spq_pkg::t_cell_cmd  w_cmd;
    spq_pkg::t_entry     w_entry [CAPACITY];
    logic                w_behind [CAPACITY];
    logic                w_occ [CAPACITY];
    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    logic [CW+4:0]       w_count_wide;

    // Handshake and queue state flags
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // Build the command broadcast to all cells
    always_comb begin
        w_cmd.entry.id   = i_req.request_id;
        w_cmd.entry.prio = i_req.prio;
        w_cmd.op         = spq_pkg::OP_HOLD;
        if (w_acc && (i_req.kind == spq_pkg::KIND_INSERT) && !w_full) begin
            w_cmd.op = spq_pkg::OP_INSERT;
        end else if (w_acc && (i_req.kind == spq_pkg::KIND_POP) && !w_empty) begin
            w_cmd.op = spq_pkg::OP_POP;
        end
    end

    // Chain of slots, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (r_count > CW'(g));
        if (g == 0) begin : g_head
            if (CAPACITY > 1) begin : g_right
                spq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (w_cmd),
                    .i_occ         (w_occ[g]),
                    .i_left        (w_cmd.entry),
                    .i_left_behind (1'b1),
                    .i_right       (w_entry[g+1]),
                    .o_entry       (w_entry[g]),
                    .o_behind      (w_behind[g])
                );
            end
        end else if (g == CAPACITY - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occ         (w_occ[g]),
                .i_left        (w_entry[g-1]),
                .i_left_behind (w_behind[g-1]),
                .i_right       (w_entry[g]),
                .o_entry       (w_entry[g]),
                .o_behind      (w_behind[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occ         (w_occ[g]),
                .i_left        (w_entry[g-1]),
                .i_left_behind (w_behind[g-1]),
                .i_right       (w_entry[g+1]),
                .o_entry       (w_entry[g]),
                .o_behind      (w_behind[g])
            );
        end
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        unique case (w_cmd.op)
            spq_pkg::OP_INSERT: n_count = r_count + CW'(1);
            spq_pkg::OP_POP:    n_count = r_count - CW'(1);
            default:            n_count = r_count;
        endcase
    end

    assign w_count_wide = {5'd0, n_count};

    // Form the result word and the output valid
    always_comb begin
        n_rsp.status    = spq_pkg::ST_DONE;
        n_rsp.out_id    = 8'd0;
        n_rsp.out_prio  = 3'd0;
        n_rsp.occupancy = w_count_wide[4:0];
        if (w_acc && (i_req.kind == spq_pkg::KIND_INSERT) && w_full) begin
            n_rsp.status = spq_pkg::ST_FULL;
        end else if (w_acc && (i_req.kind == spq_pkg::KIND_POP) && w_empty) begin
            n_rsp.status = spq_pkg::ST_EMPTY;
        end else if (w_cmd.op == spq_pkg::OP_POP) begin
            n_rsp.out_id   = w_entry[0].id;
            n_rsp.out_prio = w_entry[0].prio;
        end
        priority if (w_acc) begin
            n_rsp_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Hold the result word until a new command is accepted
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.status    = r_rsp.status;
    assign o_rsp.out_id    = r_rsp.out_id;
    assign o_rsp.out_prio  = r_rsp.out_prio;
    assign o_rsp.occupancy = r_rsp.occupancy;

    // Checks on the count, the ordering of the chain and the popped word
    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SPQ_ASSERT_NOW(a_head_sorted, i_clk, i_rst_n, r_count >= CW'(2), w_entry[0].prio >= w_entry[1].prio, "head out of order")
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_cmd.op == spq_pkg::OP_INSERT, r_count == $past(r_count) + CW'(1), "insert did not grow count")
    `SPQ_ASSERT_NEXT(a_pop_head, i_clk, i_rst_n, w_cmd.op == spq_pkg::OP_POP, r_rsp.out_prio == $past(w_entry[0].prio), "popped word is not the head")

endmodule

`default_nettype wire

FILE: sim/tb_stable_priority_queue.sv
// Testbench for stable_priority_queue: directed and burst-random traffic, sorted-list predictor.
`timescale 1ns / 1ps

module tb_stable_priority_queue;

    localparam int QCAP           = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 40;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    stable_priority_queue #(
        .CAPACITY(QCAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predictor state: sorted entries, head at slot 0
    spq_pkg::t_entry sorted_slots [QCAP];
    int              stored_count;
    spq_pkg::t_rsp   awaited_rsp [$];

    int         send_idle_pct;
    int         recv_idle_pct;
    int         error_count;
    int         quiet_cycles;
    int         n_inserts;
    int         n_pops;
    int         n_full_drops;
    int         n_empty_pops;
    int         peak_occupancy;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Work out the result word of one command and update the predicted store
    function automatic spq_pkg::t_rsp predict_queue_op(logic kind, logic [7:0] id,
                                                       logic [2:0] prio);
        spq_pkg::t_rsp res;
        int            pos;
        res = '{status: spq_pkg::ST_DONE, out_id: 8'd0, out_prio: 3'd0, occupancy: 5'd0};
        if (kind == spq_pkg::KIND_INSERT) begin
            if (stored_count >= QCAP) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                // advance past every entry of equal or higher priority
                while (pos < stored_count && sorted_slots[pos].prio >= prio)
                    pos++;
                for (int i = stored_count; i > pos; i--)
                    sorted_slots[i] = sorted_slots[i-1];
                sorted_slots[pos] = '{id: id, prio: prio};
                stored_count++;
            end
        end else begin
            if (stored_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.out_id   = sorted_slots[0].id;
                res.out_prio = sorted_slots[0].prio;
                for (int i = 1; i < stored_count; i++)
                    sorted_slots[i-1] = sorted_slots[i];
                stored_count--;
            end
        end
        res.occupancy = stored_count[4:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Sample both channels at the rising edge: check results, predict accepted words
    always @(posedge i_clk) begin
        spq_pkg::t_rsp want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_rsp.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", rsp_if.status, want.status);
                    if (rsp_if.out_id !== want.out_id)
                        report_mismatch("out_id", rsp_if.out_id, want.out_id);
                    if (rsp_if.out_prio !== want.out_prio)
                        report_mismatch("out_prio", rsp_if.out_prio, want.out_prio);
                    if (rsp_if.occupancy !== want.occupancy)
                        report_mismatch("occupancy", rsp_if.occupancy, want.occupancy);
                end
            end
            if (req_if.valid && req_if.ready) begin
                want = predict_queue_op(req_if.kind, req_if.request_id, req_if.prio);
                awaited_rsp.push_back(want);
                if (req_if.kind == spq_pkg::KIND_INSERT) n_inserts++;
                else n_pops++;
                if (want.status == spq_pkg::ST_FULL) n_full_drops++;
                if (want.status == spq_pkg::ST_EMPTY) n_empty_pops++;
                if (stored_count > peak_occupancy) peak_occupancy = stored_count;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one command word; hold it until accepted
    task automatic send_word(logic kind, logic [7:0] id, logic [2:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_if.valid      <= 1'b0;
            req_if.request_id <= 8'($urandom_range(255));
        end
        @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.request_id <= id;
        req_if.prio       <= prio;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic test_empty_pop();
        send_word(spq_pkg::KIND_POP, 8'hFF, 3'd7);
    endtask

    // Fill the store with mixed priorities and ties
    task automatic test_order_and_ties();
        logic [2:0] fill_prio [16] = '{3'd3, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1, 3'd6, 3'd5,
                                       3'd3, 3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd3};
        logic [7:0] fill_id   [16] = '{8'h00, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h80, 8'h7F, 8'h03,
                                       8'h04, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'h99, 8'h66, 8'hFF};
        for (int i = 0; i < 16; i++)
            send_word(spq_pkg::KIND_INSERT, fill_id[i], fill_prio[i]);
    endtask

    // Insert into the full store, then drain a few from the head
    task automatic test_full_drop();
        send_word(spq_pkg::KIND_INSERT, 8'hEE, 3'd7);
        for (int i = 0; i < 6; i++)
            send_word(spq_pkg::KIND_POP, 8'($urandom_range(255)), 3'($urandom_range(7)));
    endtask

    // Bursts of inserts or pops so the store swings between empty and full
    task automatic test_random_traffic(int n_words, int send_pct, int recv_pct);
        int         sent;
        int         burst_len;
        logic       burst_kind;
        logic       kind;
        logic [2:0] prio;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_words) begin
            burst_len  = $urandom_range(1, 20);
            burst_kind = 1'($urandom_range(1));
            for (int j = 0; j < burst_len && sent < n_words; j++) begin
                kind = ($urandom_range(9) == 0) ? ~burst_kind : burst_kind;
                case ($urandom_range(6))
                    0:       prio = 3'd0;
                    1:       prio = 3'($urandom_range(6, 7));
                    default: prio = 3'($urandom_range(1, 5));
                endcase
                send_word(kind, 8'($urandom_range(255)), prio);
                sent++;
            end
        end
    endtask

    initial begin
        req_if.valid      = 1'b0;
        req_if.kind       = spq_pkg::KIND_INSERT;
        req_if.request_id = 8'd0;
        req_if.prio       = 3'd0;
        rsp_if.ready      = 1'b0;
        stored_count      = 0;
        error_count       = 0;
        quiet_cycles      = 0;
        n_inserts         = 0;
        n_pops            = 0;
        n_full_drops      = 0;
        n_empty_pops      = 0;
        peak_occupancy    = 0;
        send_idle_pct     = 34;
        recv_idle_pct     = 47;

        // Hold reset low, then release it on a falling edge
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pop();
        test_order_and_ties();
        test_full_drop();
        test_random_traffic(375, 34, 47);
        test_random_traffic(375, 47, 34);
        test_random_traffic(375, 0, 0);

        // Drop valid, drain the remaining results
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d inserts and %0d pops, %0d dropped on full, %0d pops on empty",
                 n_inserts, n_pops, n_full_drops, n_empty_pops);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_occupancy, QCAP, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
